FILE: design/dadc_pkg.sv
package dadc_pkg;

  localparam int unsigned SampleW = 12;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned SumW    = 15;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned ProdW   = 2 * SampleW;

  // Samples per axis in one sequence is eight, so the mean is the sum shifted by three.
  localparam int unsigned MeanShift = 3;

  localparam logic [SampleW-1:0] FullScaleMv = 12'd3300;
  localparam logic [SampleW-1:0] AdcMax      = 12'd4095;
  localparam logic [SlotW-1:0]   FirstSlot   = 4'd0;
  localparam logic [SlotW-1:0]   LastSlot    = 4'd15;
  localparam logic [ModeW-1:0]   ModeTrackX  = 2'd0;

  localparam int unsigned WindowLengthDef = 10;

  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 88;

  function automatic logic [SampleW-1:0] to_millivolts(input logic [SampleW-1:0] mean);
    logic [ProdW-1:0] prod;
    prod = ProdW'(mean) * ProdW'(FullScaleMv);
    return prod[ProdW-1:SampleW];
  endfunction

endpackage

FILE: design/dual_axis_adc_average_minmax.sv
// Channel   Dir  Beat payload (lowest bit first)
// s_axis    in   sample[11:0], slot[15:12]
// m_axis    out  mean_x, mean_y_inverted, millivolts_x, millivolts_y,
//                tracked_mv, min_mv, max_mv (12 bits each), 4 zero bits on top
// cfg       in   display_mode, written whenever cfg_we_i is high
//
// One input beat is taken every cycle while s_axis_tready is high. After the beat with
// slot 15 is taken, its result passes the input register, mean register, millivolt
// register and output register, each a short step of logic.
// Reset (rst_ni low) clears the sums, the window counter, the minimum (to 3300),
// the maximum, the display mode and all valid flags.
// The input and mean stages each move forward whenever the stage after them is empty
// or moving, so they fill while m_axis stalls; the millivolt and output registers
// advance together whenever the output is empty or taken. s_axis_tready drops only
// while a slot 15 beat waits behind a full mean stage that a stalled output blocks.
module dual_axis_adc_average_minmax
  import dadc_pkg::*;
#(
  parameter int unsigned WINDOW_LENGTH = WindowLengthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // sample[11:0], slot[15:12]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // mean_x, mean_y_inverted, millivolts_x,
                                              // millivolts_y, tracked_mv, min_mv,
                                              // max_mv, zero padding
  input  logic                cfg_we_i,
  input  logic [ModeW-1:0]    cfg_wdata_i
);

  localparam int unsigned WinCntW = $clog2(WINDOW_LENGTH + 1);
  localparam logic [WinCntW-1:0] WinLen = WinCntW'(WINDOW_LENGTH);

  // Display mode register.
  logic [ModeW-1:0] mode_q;

  // Stage A: the accepted beat.
  logic               a_valid_q;
  logic [SampleW-1:0] a_sample_q;
  logic [SlotW-1:0]   a_slot_q;
  logic               a_done;
  logic               a_ready;

  // Running sums.
  logic [SumW-1:0] sum_x_q, sum_x_d;
  logic [SumW-1:0] sum_y_q, sum_y_d;

  // Stage B: the two means.
  logic               b_valid_q;
  logic [SampleW-1:0] b_mean_x_q, b_mean_y_q;
  logic               b_ready;

  // Stage C: means plus millivolts.
  logic               c_valid_q;
  logic [SampleW-1:0] c_mean_x_q, c_mean_y_q, c_mv_x_q, c_mv_y_q, c_tracked_q;
  logic               c_ready;
  logic [SampleW-1:0] mv_x, mv_y;

  // Window tracking.
  logic [WinCntW-1:0] win_cnt_q, win_cnt_d;
  logic [SampleW-1:0] lowest_q, lowest_d, highest_q, highest_d;
  logic [WinCntW-1:0] win_base;
  logic [SampleW-1:0] low_base, high_base;

  // Output register.
  logic               o_valid_q;
  logic [SampleW-1:0] o_mean_x_q, o_mean_y_q, o_mv_x_q, o_mv_y_q, o_tracked_q;
  logic [SampleW-1:0] o_min_q, o_max_q;

  // Handshake chain, from the output back to the input.
  assign c_ready       = !o_valid_q || m_axis_tready;
  assign b_ready       = !b_valid_q || (c_ready);
  // A beat that does not end the sequence only updates the sums and needs no room ahead.
  assign a_done        = a_valid_q && ((a_slot_q != LastSlot) || b_ready);
  assign a_ready       = !a_valid_q || a_done;
  assign s_axis_tready = a_ready;

  // Sum update for the beat leaving stage A.
  always_comb begin
    sum_x_d = sum_x_q;
    sum_y_d = sum_y_q;
    if (a_slot_q == FirstSlot) begin
      sum_x_d = SumW'(a_sample_q);
      sum_y_d = '0;
    end else if (!a_slot_q[0]) begin
      sum_x_d = sum_x_q + SumW'(a_sample_q);
    end else begin
      sum_y_d = sum_y_q + SumW'(a_sample_q);
    end
  end

  assign mv_x = to_millivolts(b_mean_x_q);
  assign mv_y = to_millivolts(b_mean_y_q);

  // The window restarts before the first result once the count has reached its length.
  always_comb begin
    if (win_cnt_q >= WinLen) begin
      win_base  = '0;
      low_base  = FullScaleMv;
      high_base = '0;
    end else begin
      win_base  = win_cnt_q;
      low_base  = lowest_q;
      high_base = highest_q;
    end
    win_cnt_d = win_base + WinCntW'(1);
    lowest_d  = (c_tracked_q < low_base)  ? c_tracked_q : low_base;
    highest_d = (c_tracked_q > high_base) ? c_tracked_q : high_base;
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModeTrackX;
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
      sum_x_q   <= '0;
      sum_y_q   <= '0;
      win_cnt_q <= '0;
      lowest_q  <= FullScaleMv;
      highest_q <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (a_ready) begin
        a_valid_q <= s_axis_tvalid;
      end
      if (a_done) begin
        sum_x_q <= sum_x_d;
        sum_y_q <= sum_y_d;
      end
      if (b_ready) begin
        b_valid_q <= a_done && (a_slot_q == LastSlot);
      end
      if (c_ready) begin
        c_valid_q <= b_valid_q;
      end
      if (c_ready && c_valid_q) begin
        win_cnt_q <= win_cnt_d;
        lowest_q  <= lowest_d;
        highest_q <= highest_d;
      end
      if (c_ready) begin
        o_valid_q <= c_valid_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (a_ready) begin
      a_sample_q <= s_axis_tdata[SampleW-1:0];
      a_slot_q   <= s_axis_tdata[SampleW+SlotW-1:SampleW];
    end
    if (b_ready) begin
      b_mean_x_q <= sum_x_d[SumW-1:MeanShift];
      b_mean_y_q <= AdcMax - sum_y_d[SumW-1:MeanShift];
    end
    if (c_ready) begin
      c_mean_x_q  <= b_mean_x_q;
      c_mean_y_q  <= b_mean_y_q;
      c_mv_x_q    <= mv_x;
      c_mv_y_q    <= mv_y;
      c_tracked_q <= (mode_q == ModeTrackX) ? mv_x : mv_y;
    end
    if (c_ready) begin
      o_mean_x_q  <= c_mean_x_q;
      o_mean_y_q  <= c_mean_y_q;
      o_mv_x_q    <= c_mv_x_q;
      o_mv_y_q    <= c_mv_y_q;
      o_tracked_q <= c_tracked_q;
      o_min_q     <= lowest_d;
      o_max_q     <= highest_d;
    end
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata  = {{(OutDataW - 7 * SampleW){1'b0}},
                          o_max_q, o_min_q, o_tracked_q, o_mv_y_q, o_mv_x_q,
                          o_mean_y_q, o_mean_x_q};

`ifndef ASSERT_OFF
  // The reported value always lies between the window minimum and maximum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_valid_q |-> (o_min_q <= o_tracked_q) && (o_tracked_q <= o_max_q))
    else $error("tracked value outside window min/max");

  // The window counter never passes the window length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_cnt_q <= WinLen)
    else $error("window counter overran");

  // Input backpressure only comes from a stalled, full output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (o_valid_q && !m_axis_tready))
    else $error("input stalled without output backpressure");

  // Millivolt values stay below full scale.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_valid_q |-> (o_mv_x_q < FullScaleMv) && (o_mv_y_q < FullScaleMv))
    else $error("millivolt value at or above full scale");
`endif

endmodule
